// File: sv/jse_pkg.sv
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared payload types, classification record and character constants.
// ----------------------------------------------------------------------------
package jse_pkg;

    // Characters used in the escaped text.
    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_LOW_B  = 16'h0062;
    localparam logic [15:0] CH_LOW_F  = 16'h0066;
    localparam logic [15:0] CH_LOW_N  = 16'h006E;
    localparam logic [15:0] CH_LOW_R  = 16'h0072;
    localparam logic [15:0] CH_LOW_T  = 16'h0074;
    localparam logic [15:0] CH_LOW_U  = 16'h0075;

    // Control characters with a short escape.
    localparam logic [15:0] CTL_BS = 16'h0008;
    localparam logic [15:0] CTL_HT = 16'h0009;
    localparam logic [15:0] CTL_LF = 16'h000A;
    localparam logic [15:0] CTL_FF = 16'h000C;
    localparam logic [15:0] CTL_CR = 16'h000D;

    // Units below this value are control characters.
    localparam logic [15:0] FIRST_PRINTABLE = 16'h0020;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Input request payload.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        carries_unit;
        logic        starts_string;
        logic        ends_string;
    } in_t;

    // Output request payload.
    typedef struct packed {
        logic [15:0] out_unit;
        logic        last_of_run;
    } out_t;

    // Shape of the body emitted between the optional quotes.
    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_PLAIN,
        BODY_PAIR,
        BODY_HEX
    } body_t;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic        open_q;
        logic        close_q;
        body_t       body;
        logic [15:0] unit;
        logic [3:0]  total;
    } cls_t;

    // Number of units in a body of the given shape.
    function automatic logic [2:0] body_len(input body_t b);
        logic [2:0] len;
        case (b)
            BODY_PLAIN: len = 3'd1;
            BODY_PAIR:  len = 3'd2;
            BODY_HEX:   len = 3'd6;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    // Lowercase hex character for a nibble.
    function automatic logic [15:0] hex_char(input logic [3:0] v);
        logic [15:0] ch;
        if (v < 4'd10)
        begin
            ch = 16'h0030 + {12'd0, v};
        end
        else
        begin
            ch = 16'h0061 + {12'd0, v - 4'd10};
        end
        return ch;
    endfunction

endpackage

// File: sv/jse_front.sv
// ----------------------------------------------------------------------------
// JSON string escaper front end
// Masks the incoming unit and classifies the request into a compact record.
// ----------------------------------------------------------------------------
module jse_front #(
    parameter int UNIT_BITS = 8
) (
    input  logic           in_valid,
    output logic           in_ready,
    input  jse_pkg::in_t   in_data,
    output logic           push_valid,
    input  logic           push_ready,
    output jse_pkg::cls_t  push_data
);

    localparam logic [15:0] UNIT_MASK = 16'((32'd1 << UNIT_BITS) - 32'd1);

    logic [15:0]   unit;
    jse_pkg::cls_t rec;

    // Classify the unit by its escape form.
    always_comb
    begin
        unit          = in_data.code_unit & UNIT_MASK;
        rec.open_q    = in_data.starts_string;
        rec.close_q   = in_data.ends_string;
        rec.unit      = unit;
        rec.body      = jse_pkg::BODY_NONE;
        if (in_data.carries_unit)
        begin
            if (unit == jse_pkg::CH_QUOTE || unit == jse_pkg::CH_BSLASH)
            begin
                rec.body = jse_pkg::BODY_PAIR;
            end
            else if (unit >= jse_pkg::FIRST_PRINTABLE)
            begin
                rec.body = jse_pkg::BODY_PLAIN;
            end
            else
            begin
                rec.body = jse_pkg::BODY_PAIR;
                case (unit)
                    jse_pkg::CTL_BS: rec.unit = jse_pkg::CH_LOW_B;
                    jse_pkg::CTL_FF: rec.unit = jse_pkg::CH_LOW_F;
                    jse_pkg::CTL_LF: rec.unit = jse_pkg::CH_LOW_N;
                    jse_pkg::CTL_CR: rec.unit = jse_pkg::CH_LOW_R;
                    jse_pkg::CTL_HT: rec.unit = jse_pkg::CH_LOW_T;
                    default:         rec.body = jse_pkg::BODY_HEX;
                endcase
            end
        end
        rec.total = {3'd0, rec.open_q} + {3'd0, rec.close_q}
                  + {1'b0, jse_pkg::body_len(rec.body)};
    end

    // Requests that produce nothing are taken and dropped here.
    assign push_data  = rec;
    assign push_valid = in_valid && (rec.total != 4'd0);
    assign in_ready   = push_ready;

endmodule

// File: sv/jse_queue.sv
// ----------------------------------------------------------------------------
// JSON string escaper queue
// Small FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module jse_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  jse_pkg::cls_t  push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output jse_pkg::cls_t  pop_data
);

    localparam int PTR_BITS = (jse_pkg::QUEUE_DEPTH > 1) ? $clog2(jse_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(jse_pkg::QUEUE_DEPTH + 1);

    jse_pkg::cls_t         mem_reg [jse_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    // Handshake status.
    assign push_ready = (count_reg != CNT_BITS'(jse_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(jse_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(jse_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: sv/jse_back.sv
// ----------------------------------------------------------------------------
// JSON string escaper back end
// Walks a classified request into out_data_reg, one unit per unstalled cycle.
// ----------------------------------------------------------------------------
module jse_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  jse_pkg::cls_t  pop_data,
    output logic           out_valid,
    input  logic           out_ready,
    output jse_pkg::out_t  out_data
);

    logic [2:0]    idx_reg;
    logic [2:0]    idx_next;
    logic          out_valid_reg;
    jse_pkg::out_t out_data_reg;
    logic          load;
    logic          step;
    logic          last;
    logic [2:0]    pos;
    logic [15:0]   unit_sel;

    // Pick the unit at the current position of the request.
    always_comb
    begin
        load     = !out_valid_reg || out_ready;
        step     = pop_valid && load;
        last     = ({1'b0, idx_reg} == (pop_data.total - 4'd1));
        pos      = idx_reg - {2'd0, pop_data.open_q};
        unit_sel = jse_pkg::CH_QUOTE;
        if (!(pop_data.open_q && idx_reg == 3'd0)
            && pos < jse_pkg::body_len(pop_data.body))
        begin
            case (pop_data.body)
                jse_pkg::BODY_PLAIN:
                begin
                    unit_sel = pop_data.unit;
                end
                jse_pkg::BODY_PAIR:
                begin
                    unit_sel = (pos == 3'd0) ? jse_pkg::CH_BSLASH : pop_data.unit;
                end
                jse_pkg::BODY_HEX:
                begin
                    case (pos)
                        3'd0:    unit_sel = jse_pkg::CH_BSLASH;
                        3'd1:    unit_sel = jse_pkg::CH_LOW_U;
                        3'd2:    unit_sel = jse_pkg::hex_char(pop_data.unit[15:12]);
                        3'd3:    unit_sel = jse_pkg::hex_char(pop_data.unit[11:8]);
                        3'd4:    unit_sel = jse_pkg::hex_char(pop_data.unit[7:4]);
                        default: unit_sel = jse_pkg::hex_char(pop_data.unit[3:0]);
                    endcase
                end
                default:
                begin
                    unit_sel = jse_pkg::CH_QUOTE;
                end
            endcase
        end
        idx_next  = idx_reg;
        if (step)
        begin
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
        end
        pop_ready = step && last;
    end

    // Output data register.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg.out_unit    <= unit_sel;
            out_data_reg.last_of_run <= last;
        end
    end

    // Position counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: sv/json_string_escaper.sv
// ----------------------------------------------------------------------------
// JSON string escaper
// Quotes and escapes a stream of string code units into JSON text.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid / in_ready  jse_pkg::in_t  (one code unit)
//   out       output     out_valid/out_ready  jse_pkg::out_t (one text unit)
//
// The output runs at one unit per cycle while out_ready is high; a request
// holds the back-end sequencer until all the units it produces (1 to 8)
// are sent, and one that produces nothing is taken and dropped at the front.
// A two-entry queue lets the front accept while the back is busy.
// Reset clears the queue, the sequencer position and the output valid.
// A stalled output holds its register; the queue fills and then holds input.
// ----------------------------------------------------------------------------
module json_string_escaper #(
    parameter int UNIT_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  jse_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output jse_pkg::out_t out_data
);

    logic          push_valid;
    logic          push_ready;
    jse_pkg::cls_t push_data;
    logic          pop_valid;
    logic          pop_ready;
    jse_pkg::cls_t pop_data;

    // Classification.
    jse_front #(
        .UNIT_BITS (UNIT_BITS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue.
    jse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Unit sequencer.
    jse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// JSON string escaper testbench
// Drives code-unit requests into the escaper, predicts the quoted and escaped
// text of each accepted request, and checks every output unit in order under
// several sender and receiver idling patterns, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import jse_pkg::*;

    localparam int UNIT_BITS   = 8;
    localparam int CLK_HALF    = 5;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_TICKS = 24;
    localparam int HOLD_TICKS  = 300;
    localparam int PRINT_LIMIT = 40;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    // Expected text units, oldest first.
    out_t escaped_text[$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_asks       = 0;
    int mismatch_count  = 0;
    int requests_sent   = 0;
    int units_checked   = 0;
    int quiet_ticks     = 0;

    json_string_escaper #(
        .UNIT_BITS (UNIT_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Print one line per mismatch, up to PRINT_LIMIT, and keep the tally of all.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("[%0t] error: %s", $time, what);
        end
    endtask

    // Lowercase hex character for the low nibble of a value.
    function automatic logic [15:0] nibble_char(input logic [15:0] v);
        logic [15:0] nib;
        nib = {12'd0, v[3:0]};
        return (nib < 16'd10) ? 16'h0030 + nib : 16'h0057 + nib;
    endfunction

    // Append one expected text unit.
    function automatic void push_text(input logic [15:0] ch);
        out_t item;
        item.out_unit    = ch;
        item.last_of_run = 1'b0;
        escaped_text.push_back(item);
    endfunction

    // Work out the text that one accepted request produces.
    function automatic void predict_escape(input in_t req);
        logic [15:0] mask;
        logic [15:0] ch;
        int          before_len;
        mask       = (UNIT_BITS >= 16) ? 16'hFFFF : 16'((17'd1 << UNIT_BITS) - 17'd1);
        ch         = req.code_unit & mask;
        before_len = escaped_text.size();
        if (req.starts_string)
        begin
            push_text(CH_QUOTE);
        end
        if (req.carries_unit)
        begin
            if (ch >= FIRST_PRINTABLE && ch != CH_QUOTE && ch != CH_BSLASH)
            begin
                push_text(ch);
            end
            else
            begin
                push_text(CH_BSLASH);
                case (ch)
                    CH_QUOTE, CH_BSLASH: push_text(ch);
                    CTL_BS:              push_text(CH_LOW_B);
                    CTL_FF:              push_text(CH_LOW_F);
                    CTL_LF:              push_text(CH_LOW_N);
                    CTL_CR:              push_text(CH_LOW_R);
                    CTL_HT:              push_text(CH_LOW_T);
                    default:
                    begin
                        push_text(CH_LOW_U);
                        push_text(nibble_char(ch >> 12));
                        push_text(nibble_char(ch >> 8));
                        push_text(nibble_char(ch >> 4));
                        push_text(nibble_char(ch));
                    end
                endcase
            end
        end
        if (req.ends_string)
        begin
            push_text(CH_QUOTE);
        end
        if (escaped_text.size() > before_len)
        begin
            escaped_text[escaped_text.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    function automatic in_t make_req(input logic [15:0] cu, input logic has,
                                     input logic first, input logic last);
        in_t req;
        req.code_unit     = cu;
        req.carries_unit  = has;
        req.starts_string = first;
        req.ends_string   = last;
        return req;
    endfunction

    // Send one request; valid stays high between back-to-back requests.
    task automatic send_request(input in_t req);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_escape(req);
        requests_sent++;
    endtask

    // Random code unit, weighted toward the classes that get escaped.
    function automatic logic [15:0] random_unit();
        logic [15:0] cu;
        case ($urandom_range(9))
            0, 1, 2: cu = 16'($urandom_range(16'h20, 16'hFF));
            3:       cu = $urandom_range(1) ? CH_QUOTE : CH_BSLASH;
            4:
            begin
                case ($urandom_range(4))
                    0:       cu = CTL_BS;
                    1:       cu = CTL_HT;
                    2:       cu = CTL_LF;
                    3:       cu = CTL_FF;
                    default: cu = CTL_CR;
                endcase
            end
            5:       cu = 16'($urandom_range(0, 31));
            default: cu = 16'($urandom_range(0, 16'hFFFF));
        endcase
        // Junk in the upper byte must be ignored by a byte-wide block.
        if ($urandom_range(3) == 0)
        begin
            cu[15:8] = 8'($urandom);
        end
        return cu;
    endfunction

    // Receiver: random stalls, plus a long hold-off when one is asked for.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_TICKS;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare each accepted output unit with the oldest expectation.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (escaped_text.size() == 0)
            begin
                report_mismatch($sformatf("unexpected unit %h last %b",
                                          out_data.out_unit, out_data.last_of_run));
            end
            else
            begin
                want = escaped_text.pop_front();
                units_checked++;
                if (out_data.out_unit !== want.out_unit)
                begin
                    report_mismatch($sformatf("out_unit %h, expected %h",
                                              out_data.out_unit, want.out_unit));
                end
                if (out_data.last_of_run !== want.last_of_run)
                begin
                    report_mismatch($sformatf("last_of_run %b, expected %b on unit %h",
                                              out_data.last_of_run, want.last_of_run,
                                              want.out_unit));
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_ticks = 0;
        end
        else
        begin
            quiet_ticks++;
            if (quiet_ticks >= QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_ticks);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Field extremes, every escape form and the corner cases of the flags.
    task automatic test_directed_escapes();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_request(make_req(16'h0000, 1'b0, 1'b1, 1'b1));   // empty string
        send_request(make_req(16'h1234, 1'b0, 1'b0, 1'b0));   // carries nothing
        send_request(make_req(16'h0000, 1'b1, 1'b1, 1'b1));   // NUL, longest run
        send_request(make_req(16'h001F, 1'b1, 1'b1, 1'b0));
        send_request(make_req(16'h0020, 1'b1, 1'b0, 1'b0));
        send_request(make_req(16'h0021, 1'b1, 1'b0, 1'b0));
        send_request(make_req(CH_QUOTE, 1'b1, 1'b0, 1'b0));
        send_request(make_req(CH_BSLASH, 1'b1, 1'b0, 1'b0));
        send_request(make_req(CTL_BS, 1'b1, 1'b0, 1'b0));
        send_request(make_req(CTL_HT, 1'b1, 1'b0, 1'b0));
        send_request(make_req(CTL_LF, 1'b1, 1'b0, 1'b0));
        send_request(make_req(CTL_FF, 1'b1, 1'b0, 1'b0));
        send_request(make_req(CTL_CR, 1'b1, 1'b0, 1'b0));
        send_request(make_req(16'h000B, 1'b1, 1'b0, 1'b0));
        send_request(make_req(16'h007F, 1'b1, 1'b0, 1'b0));
        send_request(make_req(16'h00FF, 1'b1, 1'b0, 1'b1));
        // Upper bits are dropped before the unit is classified.
        send_request(make_req(16'hFF22, 1'b1, 1'b1, 1'b0));
        send_request(make_req(16'hAB0A, 1'b1, 1'b0, 1'b0));
        send_request(make_req(16'hFFFF, 1'b1, 1'b0, 1'b0));
        send_request(make_req(16'h5A5C, 1'b1, 1'b0, 1'b1));
        // Close before open: no nesting check is made.
        send_request(make_req(16'h0000, 1'b0, 1'b0, 1'b1));
        send_request(make_req(16'h0000, 1'b0, 1'b1, 1'b0));
        send_request(make_req(16'hA5E9, 1'b1, 1'b1, 1'b1));
        send_request(make_req(16'h8000, 1'b1, 1'b0, 1'b1));
    endtask

    // Hold the receiver off so the queue fills and the input stalls.
    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_asks++;
        for (int i = 0; i < 24; i++)
        begin
            send_request(make_req(16'($urandom_range(0, 31)) | {8'($urandom), 8'h00},
                                  1'b1, 1'b1, 1'b1));
        end
    endtask

    // Mostly well-formed strings with random content, some loose requests.
    task automatic test_random_strings(input int s_idle, input int r_stall, input int n_req);
        int   sent;
        int   len;
        logic markers;
        in_t  req;
        sender_idle_pct = s_idle;
        recv_stall_pct  = r_stall;
        sent = 0;
        while (sent < n_req)
        begin
            if ($urandom_range(99) < 15)
            begin
                req = make_req(random_unit(), 1'($urandom), 1'($urandom), 1'($urandom));
                send_request(req);
                if (req.carries_unit || req.starts_string || req.ends_string)
                begin
                    sent++;
                end
            end
            else
            begin
                len     = $urandom_range(1, 6);
                markers = ($urandom_range(9) == 0);
                if (markers)
                begin
                    // Quotes carried by unit-less requests around the body.
                    send_request(make_req(16'($urandom), 1'b0, 1'b1, 1'b0));
                end
                for (int i = 0; i < len; i++)
                begin
                    send_request(make_req(random_unit(), 1'b1,
                                          !markers && i == 0, !markers && i == len - 1));
                end
                if (markers)
                begin
                    send_request(make_req(16'($urandom), 1'b0, 1'b0, 1'b1));
                end
                sent += len;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_escapes();
        test_output_backpressure();
        test_random_strings(0, 0, 25);
        test_random_strings(53, 0, 25);
        test_random_strings(0, 53, 25);
        test_random_strings(11, 11, 25);

        // Let the last text drain out.
        in_valid       <= 1'b0;
        recv_stall_pct  = 0;
        while (escaped_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_TICKS) @(posedge clk);
        if (escaped_text.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected units never arrived",
                                      escaped_text.size()));
        end

        $display("Sent %0d requests (directed, long hold-off, four idling mixes);",
                 requests_sent);
        $display("checked %0d output units, %0d mismatches.", units_checked, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
sv/jse_pkg.sv
sv/jse_front.sv
sv/jse_queue.sv
sv/jse_back.sv
sv/json_string_escaper.sv
tb/tb_top.sv
